// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold on every clock edge.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/edf_pkg.sv =====
// ----------------------------------------------------------------------------
// edf_pkg
// Types and constants shared by the segment filter and its stream interfaces.
// ----------------------------------------------------------------------------
package edf_pkg;

  localparam int unsigned MIN_LEN_W = 23;
  localparam int unsigned TOL_W     = 16;
  localparam int unsigned CFG_IDX_W = 1;

  // 6.0 and roughly 0.35 points in Q15.8
  localparam logic [MIN_LEN_W-1:0] MIN_LEN_RST = 23'd1536;
  localparam logic [TOL_W-1:0]     DUP_TOL_RST = 16'd90;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_LENGTH = 1'b0,
    REG_DUP_TOL    = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    VERDICT_KEPT  = 2'd0,
    VERDICT_SHORT = 2'd1,
    VERDICT_DUP   = 2'd2
  } verdict_e;

endpackage

// ===== design/edf_if.sv =====
// ----------------------------------------------------------------------------
// edf stream interfaces
// Valid/ready channels for incoming segments and outgoing verdicts.
// ----------------------------------------------------------------------------
interface edf_seg_if #(
  parameter int unsigned COORD_BITS = 24
);
  logic                         valid;
  logic                         ready;
  logic                         first_of_page;
  logic                         orientation;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;

  modport source (
    output valid, first_of_page, orientation, start_x, start_y, end_x, end_y,
    input  ready
  );
  modport sink (
    input  valid, first_of_page, orientation, start_x, start_y, end_x, end_y,
    output ready
  );
endinterface

interface edf_res_if
  import edf_pkg::*;
#(
  parameter int unsigned COORD_BITS = 24
);
  logic                         valid;
  logic                         ready;
  verdict_e                     verdict;
  logic                         out_orientation;
  logic signed [COORD_BITS-1:0] out_start_x;
  logic signed [COORD_BITS-1:0] out_start_y;
  logic signed [COORD_BITS-1:0] out_end_x;
  logic signed [COORD_BITS-1:0] out_end_y;

  modport source (
    output valid, verdict, out_orientation, out_start_x, out_start_y, out_end_x,
           out_end_y,
    input  ready
  );
  modport sink (
    input  valid, verdict, out_orientation, out_start_x, out_start_y, out_end_x,
           out_end_y,
    output ready
  );
endinterface

// ===== design/edge_dedup_filter.sv =====
// ----------------------------------------------------------------------------
// edge_dedup_filter
// Length and duplicate filter for horizontal and vertical line segments.
// ----------------------------------------------------------------------------
// Each segment transfer yields one result transfer: a verdict (kept, too short,
// duplicate) plus an echo of the segment. A segment is too short when its span
// along its own axis, saturated to the largest positive coordinate, is below
// min_length. Otherwise it is compared against the kept history, a ring of
// DUP_WINDOW entries held in a single-port-read synchronous RAM, one entry per
// cycle; a hit needs the same orientation and all four coordinates within
// dup_tolerance (inclusive). Kept segments are written over the oldest entry.
// first_of_page empties the history before its own segment is judged.
// How long a segment occupies the sequencer grows with the number of history
// entries compared (at most DUP_WINDOW), as the scan through the history RAM
// sets it; a too-short segment skips the scan. The result sits in an output
// register, so the next segment is taken while the previous result still
// waits for its transfer. No clearing pass is needed after reset: only
// entries below the fill count are ever read. The user is to write the
// configuration registers through the plain write port only while the block
// is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module edge_dedup_filter
  import edf_pkg::*;
#(
  parameter int unsigned DUP_WINDOW = 48,
  parameter int unsigned COORD_BITS = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [MIN_LEN_W-1:0] cfg_wdata_i,
  // streams
  edf_seg_if.sink              seg_i,
  edf_res_if.source            res_o
);

  localparam int unsigned IDX_W  = (DUP_WINDOW > 1) ? $clog2(DUP_WINDOW) : 1;
  localparam int unsigned CNT_W  = $clog2(DUP_WINDOW + 1);
  localparam int unsigned DIFF_W = COORD_BITS + 1;
  localparam int unsigned ENT_W  = 1 + 4 * COORD_BITS;
  localparam int unsigned CMP_W  = (COORD_BITS > MIN_LEN_W) ? COORD_BITS : MIN_LEN_W;
  localparam logic [COORD_BITS-1:0] LEN_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

  typedef enum logic [2:0] {
    S_IDLE,   // waiting for a segment
    S_DIFF,   // axis difference
    S_LEN,    // length check, start of history scan
    S_SCAN,   // one history entry per cycle
    S_WRITE,  // store kept segment
    S_DONE    // hand result to the output register
  } state_e;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_e                       state_q, state_d;
  logic [MIN_LEN_W-1:0]         min_len_q, min_len_d;
  logic [TOL_W-1:0]             tol_q, tol_d;

  logic                         orient_q, orient_d;
  logic signed [COORD_BITS-1:0] sx_q, sx_d, sy_q, sy_d, ex_q, ex_d, ey_q, ey_d;
  logic signed [DIFF_W-1:0]     diff_q, diff_d;
  verdict_e                     verdict_q, verdict_d;

  logic [CNT_W-1:0]             scan_q, scan_d;
  logic [CNT_W-1:0]             valid_cnt_q, valid_cnt_d;
  logic [IDX_W-1:0]             wr_slot_q, wr_slot_d;

  logic                         out_valid_q, out_valid_d;
  verdict_e                     out_verdict_q, out_verdict_d;
  logic                         out_orient_q, out_orient_d;
  logic signed [COORD_BITS-1:0] out_sx_q, out_sx_d, out_sy_q, out_sy_d;
  logic signed [COORD_BITS-1:0] out_ex_q, out_ex_d, out_ey_q, out_ey_d;

  // History RAM
  logic [ENT_W-1:0]             hist_mem [DUP_WINDOW];
  logic [ENT_W-1:0]             rd_data_q;
  logic                         rd_en;
  logic [IDX_W-1:0]             rd_addr;
  logic                         mem_we;

  // --------------------------------------------------------------------------
  // Datapath helpers
  // --------------------------------------------------------------------------
  function automatic logic near_same(input logic signed [COORD_BITS-1:0] a,
                                     input logic signed [COORD_BITS-1:0] b,
                                     input logic [TOL_W-1:0]             tol);
    logic signed [DIFF_W-1:0] d;
    logic [DIFF_W-1:0]        m;
    d = DIFF_W'(a) - DIFF_W'(b);
    m = d[DIFF_W-1] ? unsigned'(-d) : unsigned'(d);
    return m <= DIFF_W'(tol);
  endfunction

  // Length: |diff|, saturated to the largest positive coordinate
  logic [DIFF_W-1:0]     len_mag;
  logic [COORD_BITS-1:0] len_sat;
  logic                  too_short;

  assign len_mag   = diff_q[DIFF_W-1] ? unsigned'(-diff_q) : unsigned'(diff_q);
  assign len_sat   = (len_mag > DIFF_W'(LEN_MAX)) ? LEN_MAX : len_mag[COORD_BITS-1:0];
  assign too_short = CMP_W'(len_sat) < CMP_W'(min_len_q);

  // Compare of the entry read in the previous cycle
  logic                         ent_orient;
  logic signed [COORD_BITS-1:0] ent_sx, ent_sy, ent_ex, ent_ey;
  logic                         hit;

  assign ent_orient = rd_data_q[ENT_W-1];
  assign ent_sx     = signed'(rd_data_q[4*COORD_BITS-1 -: COORD_BITS]);
  assign ent_sy     = signed'(rd_data_q[3*COORD_BITS-1 -: COORD_BITS]);
  assign ent_ex     = signed'(rd_data_q[2*COORD_BITS-1 -: COORD_BITS]);
  assign ent_ey     = signed'(rd_data_q[COORD_BITS-1 -: COORD_BITS]);

  assign hit = (ent_orient == orient_q) &&
               near_same(ent_sx, sx_q, tol_q) && near_same(ent_sy, sy_q, tol_q) &&
               near_same(ent_ex, ex_q, tol_q) && near_same(ent_ey, ey_q, tol_q);

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d       = state_q;
    min_len_d     = min_len_q;
    tol_d         = tol_q;
    orient_d      = orient_q;
    sx_d          = sx_q;
    sy_d          = sy_q;
    ex_d          = ex_q;
    ey_d          = ey_q;
    diff_d        = diff_q;
    verdict_d     = verdict_q;
    scan_d        = scan_q;
    valid_cnt_d   = valid_cnt_q;
    wr_slot_d     = wr_slot_q;
    out_valid_d   = out_valid_q;
    out_verdict_d = out_verdict_q;
    out_orient_d  = out_orient_q;
    out_sx_d      = out_sx_q;
    out_sy_d      = out_sy_q;
    out_ex_d      = out_ex_q;
    out_ey_d      = out_ey_q;
    rd_en         = 1'b0;
    rd_addr       = scan_q[IDX_W-1:0];
    mem_we        = 1'b0;

    // result leaves on its transfer
    if (out_valid_q && res_o.ready) begin
      out_valid_d = 1'b0;
    end

    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_MIN_LENGTH: min_len_d = cfg_wdata_i;
        REG_DUP_TOL:    tol_d     = cfg_wdata_i[TOL_W-1:0];
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (seg_i.valid) begin
          orient_d = seg_i.orientation;
          sx_d     = seg_i.start_x;
          sy_d     = seg_i.start_y;
          ex_d     = seg_i.end_x;
          ey_d     = seg_i.end_y;
          if (seg_i.first_of_page) begin
            valid_cnt_d = '0;
            wr_slot_d   = '0;
          end
          state_d = S_DIFF;
        end
      end
      S_DIFF: begin
        diff_d  = orient_q ? (DIFF_W'(ey_q) - DIFF_W'(sy_q))
                           : (DIFF_W'(ex_q) - DIFF_W'(sx_q));
        state_d = S_LEN;
      end
      S_LEN: begin
        if (too_short) begin
          verdict_d = VERDICT_SHORT;
          state_d   = S_DONE;
        end else if (valid_cnt_q == '0) begin
          verdict_d = VERDICT_KEPT;
          state_d   = S_WRITE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = '0;
          scan_d  = CNT_W'(1);
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit) begin
          verdict_d = VERDICT_DUP;
          state_d   = S_DONE;
        end else if (scan_q == valid_cnt_q) begin
          verdict_d = VERDICT_KEPT;
          state_d   = S_WRITE;
        end else begin
          rd_en  = 1'b1;
          scan_d = scan_q + CNT_W'(1);
        end
      end
      S_WRITE: begin
        // reads are over before the write, so no forwarding is needed
        mem_we    = 1'b1;
        wr_slot_d = (wr_slot_q == IDX_W'(DUP_WINDOW - 1)) ? '0 : wr_slot_q + IDX_W'(1);
        if (valid_cnt_q < CNT_W'(DUP_WINDOW)) begin
          valid_cnt_d = valid_cnt_q + CNT_W'(1);
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || res_o.ready) begin
          out_valid_d   = 1'b1;
          out_verdict_d = verdict_q;
          out_orient_d  = orient_q;
          out_sx_d      = sx_q;
          out_sy_d      = sy_q;
          out_ex_d      = ex_q;
          out_ey_d      = ey_q;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      min_len_q     <= MIN_LEN_RST;
      tol_q         <= DUP_TOL_RST;
      orient_q      <= 1'b0;
      sx_q          <= '0;
      sy_q          <= '0;
      ex_q          <= '0;
      ey_q          <= '0;
      diff_q        <= '0;
      verdict_q     <= VERDICT_KEPT;
      scan_q        <= '0;
      valid_cnt_q   <= '0;
      wr_slot_q     <= '0;
      out_valid_q   <= 1'b0;
      out_verdict_q <= VERDICT_KEPT;
      out_orient_q  <= 1'b0;
      out_sx_q      <= '0;
      out_sy_q      <= '0;
      out_ex_q      <= '0;
      out_ey_q      <= '0;
    end else begin
      state_q       <= state_d;
      min_len_q     <= min_len_d;
      tol_q         <= tol_d;
      orient_q      <= orient_d;
      sx_q          <= sx_d;
      sy_q          <= sy_d;
      ex_q          <= ex_d;
      ey_q          <= ey_d;
      diff_q        <= diff_d;
      verdict_q     <= verdict_d;
      scan_q        <= scan_d;
      valid_cnt_q   <= valid_cnt_d;
      wr_slot_q     <= wr_slot_d;
      out_valid_q   <= out_valid_d;
      out_verdict_q <= out_verdict_d;
      out_orient_q  <= out_orient_d;
      out_sx_q      <= out_sx_d;
      out_sy_q      <= out_sy_d;
      out_ex_q      <= out_ex_d;
      out_ey_q      <= out_ey_d;
    end
  end

  // History RAM, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hist_mem[wr_slot_q] <= {orient_q, sx_q, sy_q, ex_q, ey_q};
    end
    if (rd_en) begin
      rd_data_q <= hist_mem[rd_addr];
    end
  end

  // --------------------------------------------------------------------------
  // Ports
  // --------------------------------------------------------------------------
  assign seg_i.ready           = (state_q == S_IDLE);
  assign res_o.valid           = out_valid_q;
  assign res_o.verdict         = out_verdict_q;
  assign res_o.out_orientation = out_orient_q;
  assign res_o.out_start_x     = out_sx_q;
  assign res_o.out_start_y     = out_sy_q;
  assign res_o.out_end_x       = out_ex_q;
  assign res_o.out_end_y       = out_ey_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `ASSERT_CLK(a_cnt_bound, valid_cnt_q <= CNT_W'(DUP_WINDOW), "fill count beyond window")
  `ASSERT_CLK(a_slot_bound, CNT_W'(wr_slot_q) < CNT_W'(DUP_WINDOW), "write slot beyond window")
  `ASSERT_IMPL(a_rd_filled, rd_en, CNT_W'(rd_addr) < valid_cnt_q, "read of unfilled entry")
  `ASSERT_IMPL(a_rw_apart, mem_we, !rd_en, "history read and write in one cycle")
  `ASSERT_NEXT(a_write_fills, mem_we, valid_cnt_q != '0, "store left history empty")

endmodule

// ===== test/edf_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// edf_tb_pkg
// Segment record and coordinate limits for the filter bench.
// ----------------------------------------------------------------------------
package edf_tb_pkg;

  localparam int unsigned COORD_W    = 24;
  localparam int unsigned HIST_DEPTH = 48;

  localparam int COORD_MAX = 2 ** (COORD_W - 1) - 1;
  localparam int COORD_MIN = -COORD_MAX - 1;

  typedef struct packed {
    logic                      orient;
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
    logic signed [COORD_W-1:0] ex;
    logic signed [COORD_W-1:0] ey;
  } seg_t;

endpackage

// ===== test/edf_checker.sv =====
// ----------------------------------------------------------------------------
// edf_checker
// Watches both streams and the register port, keeps its own copy of the kept
// history and compares every result transfer against the predicted verdict and echo.
// ----------------------------------------------------------------------------
module edf_checker
  import edf_pkg::*;
  import edf_tb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [MIN_LEN_W-1:0] cfg_wdata_i,
  edf_seg_if                   seg_i,
  edf_res_if                   res_i,
  output int unsigned          fail_cnt_o,
  output int unsigned          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [COORD_W:0] MAX_SPAN = (COORD_W + 1)'(COORD_MAX);

  typedef struct {
    verdict_e verdict;
    seg_t     echo;
  } result_t;

  logic [MIN_LEN_W-1:0] min_len_q;
  logic [TOL_W-1:0]     tol_q;
  seg_t                 hist_q [HIST_DEPTH];
  int unsigned          hist_fill;
  int unsigned          hist_slot;
  result_t              pending_results [$];

  function automatic logic [COORD_W:0] span(input logic signed [COORD_W-1:0] a,
                                            input logic signed [COORD_W-1:0] b);
    logic signed [COORD_W:0] d;
    d = a - b;
    return (d < 0) ? -d : d;
  endfunction

  function automatic logic near(input logic signed [COORD_W-1:0] a,
                                input logic signed [COORD_W-1:0] b);
    return span(a, b) <= {1'b0, {(COORD_W - TOL_W){1'b0}}, tol_q};
  endfunction

  // verdict of one segment; empties the history on a page start and updates the history ring on a keep
  function automatic verdict_e judge_segment(input logic fop, input seg_t s);
    logic [COORD_W:0] len;
    if (fop) begin
      hist_fill = 0;
      hist_slot = 0;
    end
    len = s.orient ? span(s.ey, s.sy) : span(s.ex, s.sx);
    if (len > MAX_SPAN) len = MAX_SPAN;
    if (len < min_len_q) return VERDICT_SHORT;
    for (int k = 0; k < hist_fill; k++) begin
      if (hist_q[k].orient == s.orient && near(hist_q[k].sx, s.sx) &&
          near(hist_q[k].sy, s.sy) && near(hist_q[k].ex, s.ex) &&
          near(hist_q[k].ey, s.ey)) return VERDICT_DUP;
    end
    hist_q[hist_slot] = s;
    hist_slot = (hist_slot + 1 == HIST_DEPTH) ? 0 : hist_slot + 1;
    if (hist_fill < HIST_DEPTH) hist_fill++;
    return VERDICT_KEPT;
  endfunction

  task automatic check_field(input string name, input longint exp_v, input longint got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      fail_cnt_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t head;
    seg_t    s;
    if (!rst_ni) begin
      min_len_q  = MIN_LEN_RST;
      tol_q      = DUP_TOL_RST;
      hist_fill  = 0;
      hist_slot  = 0;
      fail_cnt_o = 0;
      pending_results.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_MIN_LENGTH: min_len_q = cfg_wdata_i;
          REG_DUP_TOL:    tol_q = cfg_wdata_i[TOL_W-1:0];
          default: ;
        endcase
      end
      if (res_i.valid && res_i.ready) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with no segment outstanding");
          fail_cnt_o++;
        end else begin
          head = pending_results.pop_front();
          check_field("verdict", head.verdict, res_i.verdict);
          check_field("out_orientation", head.echo.orient, res_i.out_orientation);
          check_field("out_start_x", head.echo.sx, res_i.out_start_x);
          check_field("out_start_y", head.echo.sy, res_i.out_start_y);
          check_field("out_end_x", head.echo.ex, res_i.out_end_x);
          check_field("out_end_y", head.echo.ey, res_i.out_end_y);
        end
      end
      if (seg_i.valid && seg_i.ready) begin
        s = '{orient: seg_i.orientation, sx: seg_i.start_x, sy: seg_i.start_y,
              ex: seg_i.end_x, ey: seg_i.end_y};
        head.verdict = judge_segment(seg_i.first_of_page, s);
        head.echo    = s;
        pending_results.push_back(head);
      end
    end
    pending_o = pending_results.size();
  end

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives segments and register writes into the segment filter, with random
// gaps on both streams, and reports the checker's verdict at the end.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import edf_pkg::*;
  import edf_tb_pkg::*;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [MIN_LEN_W-1:0] cfg_wdata_i;

  int unsigned fail_cnt;
  int unsigned pending;

  // receiver hold-off request (cycles) and no-idle switches per side
  int unsigned hold_len = 0;
  bit          tx_calm  = 1'b0;
  bit          rx_calm  = 1'b0;

  // register values currently programmed, used to aim the stimulus
  int cur_min = int'(MIN_LEN_RST);
  int cur_tol = int'(DUP_TOL_RST);

  // recently offered segments, source of repeats and near copies; a little
  // deeper than the history ring so that overwritten entries come back too
  seg_t recent_segs [$];

  edf_seg_if #(.COORD_BITS(COORD_W)) seg ();
  edf_res_if #(.COORD_BITS(COORD_W)) res ();

  edge_dedup_filter #(
    .DUP_WINDOW(HIST_DEPTH),
    .COORD_BITS(COORD_W)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .seg_i      (seg),
    .res_o      (res)
  );

  edf_checker i_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .seg_i      (seg),
    .res_i      (res),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  // 4 ns clock
  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // hard stop in case a handshake never completes
  initial begin
    #2ms;
    $display("TB_ERROR");
    $finish;
  end

  function automatic seg_t mk(input logic o, input int sx, input int sy,
                              input int ex, input int ey);
    return '{orient: o, sx: COORD_W'(sx), sy: COORD_W'(sy),
             ex: COORD_W'(ex), ey: COORD_W'(ey)};
  endfunction

  // register write; always waits for a clock edge first so back-to-back writes never
  // put two assignments on the enable in one step
  task automatic write_reg(input cfg_reg_e idx, input int unsigned val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= MIN_LEN_W'(val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // offer one segment, with a random gap first unless the sender is calm.
  // valid stays high from one transfer into the next when there is no gap.
  task automatic send_seg(input logic fop, input seg_t s);
    if (!tx_calm) begin
      while ($urandom_range(99) < 37) begin
        seg.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    seg.valid         <= 1'b1;
    seg.first_of_page <= fop;
    seg.orientation   <= s.orient;
    seg.start_x       <= s.sx;
    seg.start_y       <= s.sy;
    seg.end_x         <= s.ex;
    seg.end_y         <= s.ey;
    do @(posedge clk_i); while (!seg.ready);
    recent_segs.push_back(s);
    if (recent_segs.size() > HIST_DEPTH + 16) void'(recent_segs.pop_front());
  endtask

  // sender stops and waits until every result has been taken, then lets the
  // scan of any late segment finish before anything else happens
  task automatic drain();
    seg.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  // offset of a coordinate around the tolerance edge, either sign
  function automatic int tol_offset();
    int mag;
    case ($urandom_range(3))
      0:       mag = cur_tol;
      1:       mag = cur_tol + 1;
      default: mag = int'($urandom_range(cur_tol + 1));
    endcase
    return $urandom_range(1) ? mag : -mag;
  endfunction

  function automatic logic signed [COORD_W-1:0] nudge(input logic signed [COORD_W-1:0] c);
    return $urandom_range(1) ? c + COORD_W'(tol_offset()) : c;
  endfunction

  // one random segment: mostly repeats and near copies of recent segments and
  // spans right at the length threshold, the rest small or fully random
  task automatic send_random(input int fop_pct);
    seg_t s;
    logic fop;
    int   mode;
    int   len;
    int   a;
    int   b;
    int   t;
    fop  = ($urandom_range(99) < fop_pct);
    mode = $urandom_range(99);
    s    = mk($urandom_range(1), $urandom, $urandom, $urandom, $urandom);
    if (mode < 30 && recent_segs.size() != 0) begin
      s    = recent_segs[$urandom_range(recent_segs.size() - 1)];
      s.sx = nudge(s.sx);
      s.sy = nudge(s.sy);
      s.ex = nudge(s.ex);
      s.ey = nudge(s.ey);
      if ($urandom_range(99) < 15) s.orient = ~s.orient;
    end else if (mode < 45 && recent_segs.size() != 0) begin
      s = recent_segs[$urandom_range(recent_segs.size() - 1)];
      if ($urandom_range(99) < 10) s.orient = ~s.orient;
    end else if (mode < 62) begin
      // span of min_length - 1, min_length or min_length + 1
      len = cur_min + int'($urandom_range(2)) - 1;
      if (len < 0) len = 0;
      if (len > COORD_MAX) len = COORD_MAX;
      a = COORD_MIN + int'($urandom_range(COORD_MAX - len - COORD_MIN));
      b = a + len;
      if ($urandom_range(1)) begin
        t = a;
        a = b;
        b = t;
      end
      if (s.orient) begin
        s.sy = COORD_W'(a);
        s.ey = COORD_W'(b);
      end else begin
        s.sx = COORD_W'(a);
        s.ex = COORD_W'(b);
      end
    end else if (mode < 80) begin
      s = mk($urandom_range(1), int'($urandom_range(8191)) - 4096,
             int'($urandom_range(8191)) - 4096, int'($urandom_range(8191)) - 4096,
             int'($urandom_range(8191)) - 4096);
    end
    send_seg(fop, s);
  endtask

  // one register setting; squeeze adds the long receiver hold-off and a
  // full drain in the middle of the phase
  task automatic run_phase(input int min_len, input int tol, input int n_items,
                           input int fop_pct, input bit squeeze);
    cur_min = min_len;
    cur_tol = tol;
    write_reg(REG_MIN_LENGTH, min_len);
    // junk above the tolerance width is to be masked off
    write_reg(REG_DUP_TOL, tol | ($urandom_range(127) << TOL_W));
    for (int i = 0; i < n_items; i++) begin
      if (squeeze && i == 20) begin
        hold_len = 300;
        tx_calm  = 1'b1;
      end
      if (squeeze && i == 50) tx_calm = 1'b0;
      if (squeeze && i == 80) drain();
      send_random(fop_pct);
    end
    drain();
  endtask

  // receiver: random ready, or a long hold-off when asked
  initial begin
    int unsigned n;
    res.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_len != 0) begin
        n        = hold_len;
        hold_len = 0;
        res.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      res.ready <= rx_calm || ($urandom_range(99) >= 37);
    end
  end

  // sender and phase sequencing
  initial begin
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= REG_MIN_LENGTH;
    cfg_wdata_i       <= '0;
    seg.valid         <= 1'b0;
    seg.first_of_page <= 1'b0;
    seg.orientation   <= 1'b0;
    seg.start_x       <= '0;
    seg.start_y       <= '0;
    seg.end_x         <= '0;
    seg.end_y         <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, registers at their reset values (6.0 and 90)
    send_seg(1'b1, mk(0, 0, 0, 1536, 0));             // span equals threshold: kept
    send_seg(1'b0, mk(0, 0, 0, 1535, 0));             // one short, never matched
    send_seg(1'b0, mk(0, 0, 0, 1536, 0));             // exact duplicate
    send_seg(1'b0, mk(0, 90, 90, 1626, 90));          // every coord off by tolerance
    send_seg(1'b0, mk(0, 0, 91, 1536, 0));            // one coord past tolerance
    send_seg(1'b0, mk(1, 0, 0, 0, 1536));             // vertical, y span counts
    send_seg(1'b0, mk(1, 0, 0, 1536, 0));             // vertical with no y span
    send_seg(1'b0, mk(0, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX)); // saturated span
    send_seg(1'b0, mk(1, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN));
    send_seg(1'b0, mk(0, 1536, 5, 0, 5));             // reversed direction
    send_seg(1'b0, mk(0, -1, -1, -1537, -1));
    send_seg(1'b0, mk(1, -1, COORD_MIN, -1, COORD_MAX));
    send_seg(1'b0, mk(0, 0, 0, 0, 0));                // zero length
    send_seg(1'b1, mk(0, 0, 0, 1536, 0));             // page start: history gone
    send_seg(1'b0, mk(0, 0, 91, 1536, 0));
    send_seg(1'b0, mk(0, 0, 0, 1536, 0));             // duplicate again
    drain();

    // zero threshold and tolerance, no page starts: the ring wraps
    run_phase(0, 0, 130, 0, 1'b0);
    // largest threshold and tolerance: only saturated spans survive
    run_phase(COORD_MAX, 2 ** TOL_W - 1, 80, 3, 1'b0);
    // moderate random setting with back-pressure
    run_phase($urandom_range(3000), $urandom_range(400), 150, 3, 1'b1);
    // reset values written back, no idling on either side
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    run_phase(int'(MIN_LEN_RST), int'(DUP_TOL_RST), 140, 2, 1'b0);
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    run_phase($urandom_range(20000), $urandom_range(2 ** TOL_W - 1), 120, 4, 1'b0);
    run_phase(1, 1, 110, 1, 1'b0);

    if (fail_cnt == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== edge_dedup_filter.f =====
+incdir+design
design/edf_pkg.sv
design/edf_if.sv
design/edge_dedup_filter.sv
test/edf_tb_pkg.sv
test/edf_checker.sv
test/testbench.sv
